@@ design/bfps_pkg.sv @@
package bfps_pkg;

  // Width of the byte position counter within one buffer.
  localparam int unsigned POS_BITS = 32;

  // Largest position value; a byte arriving there stops the walk.
  localparam logic [63:0] POS_MASK = (POS_BITS >= 64) ? {64{1'b1}}
                                   : ((64'd1 << POS_BITS) - 64'd1);

  localparam int unsigned PREFIX_BITS = 32;
  localparam int unsigned HDR_CNT_BITS = 5;

  // Header lengths and the byte offsets inside a header.
  localparam logic [HDR_CNT_BITS-1:0] HDR_LEN_SMALL = 5'd8;
  localparam logic [HDR_CNT_BITS-1:0] HDR_LEN_LARGE = 5'd16;
  localparam logic [HDR_CNT_BITS-1:0] HDR_TYPE_OFS  = 5'd4;

  // Output tdata: prefix_length, stop_reason, zero fill to whole bytes.
  localparam int unsigned OUT_DATA_BITS = 40;

  typedef enum logic [1:0] {
    STOP_NONE    = 2'd0,  // scanning, or ended on a box boundary
    STOP_PARTIAL = 2'd1,
    STOP_ZERO    = 2'd2,
    STOP_BELOW   = 2'd3
  } stop_e;

  // Expected type byte "mdat" for a given offset in the type field.
  function automatic logic [7:0] mdat_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h6D;
      2'd1:    c = 8'h64;
      2'd2:    c = 8'h61;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

endpackage

@@ design/bmff_fragment_prefix_scanner.sv @@
// Channel   Dir  tdata                                   tlast      tuser
// s_axis    in   [7:0] data_byte                         last_byte  -
// m_axis    out  [31:0] prefix_length, [33:32] stop_rsn  -          -
//
// One beat per cycle sustained while m_axis takes results: a byte is registered
// in the input register, then the box walker updates its state in a single
// pass (size shift, type compare, one 64-bit end/fit compute at header end, one
// position compare). The result register loads as the last beat is consumed.
// Reset clears control state only; stall of m_axis holds only the last beat
// of a buffer, all other beats keep flowing while a result waits.
module bmff_fragment_prefix_scanner
  import bfps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] data_byte
  input  logic                     s_axis_tlast,   // last_byte
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata    // [31:0] prefix_length,
                                                   // [33:32] stop_reason, rest 0
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // walker state
  logic [POS_BITS-1:0]     byte_pos_q, byte_pos_d;
  logic [POS_BITS-1:0]     box_start_q, box_start_d;
  logic [HDR_CNT_BITS-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [63:0]             box_size_q, box_size_d;
  logic                    large_q, large_d;
  logic                    mdat_q, mdat_d;
  logic [POS_BITS-1:0]     commit_q, commit_d;
  stop_e                   halt_q, halt_d;
  logic [POS_BITS-1:0]     box_end_q, box_end_d;   // start + size, valid with fit
  logic                    fit_q, fit_d;           // box end is reachable

  // output register
  logic                     out_valid_q;
  logic [OUT_DATA_BITS-1:0] out_data_q;

  logic proc;       // the byte in the input register is consumed this cycle
  logic emit;       // ...and it is the last byte of a buffer
  logic out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && (!in_last_q || out_free);
  assign emit          = proc && in_last_q;
  assign s_axis_tready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Walker next state
  logic                    fresh;
  logic                    large_cur;
  logic [63:0]             size_cur;
  logic                    mdat_cur;
  logic [POS_BITS-1:0]     start_cur;
  logic [HDR_CNT_BITS-1:0] hlen_cur, hlen_new, hc_inc;
  logic                    in_hdr;
  logic                    hdr_done;
  logic                    complete;
  logic [POS_BITS-1:0]     pos_inc;
  stop_e                   reason;

  always_comb begin
    byte_pos_d  = byte_pos_q;
    box_start_d = box_start_q;
    hdr_cnt_d   = hdr_cnt_q;
    box_size_d  = box_size_q;
    large_d     = large_q;
    mdat_d      = mdat_q;
    commit_d    = commit_q;
    halt_d      = halt_q;
    box_end_d   = box_end_q;
    fit_d       = fit_q;

    fresh     = (hdr_cnt_q == '0);
    large_cur = fresh ? 1'b0 : large_q;
    size_cur  = fresh ? 64'd0 : box_size_q;
    mdat_cur  = fresh ? 1'b0 : mdat_q;
    start_cur = fresh ? byte_pos_q : box_start_q;
    hlen_cur  = large_cur ? HDR_LEN_LARGE : HDR_LEN_SMALL;
    in_hdr    = (hdr_cnt_q < hlen_cur);
    hc_inc    = hdr_cnt_q + 5'd1;
    pos_inc   = byte_pos_q + POS_BITS'(1);
    hlen_new  = hlen_cur;
    hdr_done  = 1'b0;
    complete  = 1'b0;

    if (proc && halt_q == STOP_NONE) begin
      if (64'(byte_pos_q) == POS_MASK) begin
        // counter exhausted: the current box can never complete
        halt_d = STOP_PARTIAL;
      end else begin
        box_start_d = start_cur;
        large_d     = large_cur;
        box_size_d  = size_cur;
        mdat_d      = mdat_cur;
        if (in_hdr) begin
          if (hdr_cnt_q < HDR_TYPE_OFS || hdr_cnt_q >= HDR_LEN_SMALL) begin
            box_size_d = {size_cur[55:0], in_byte_q};
          end else begin
            mdat_d = ((hdr_cnt_q == HDR_TYPE_OFS) ? 1'b1 : mdat_cur)
                     && (in_byte_q == mdat_char(hdr_cnt_q[1:0]));
          end
          hdr_cnt_d = hc_inc;
          if (hc_inc == HDR_LEN_SMALL && !large_cur) begin
            if (box_size_d == 64'd0) begin
              halt_d = STOP_ZERO;
            end else if (box_size_d == 64'd1) begin
              // 64-bit large size follows
              large_d    = 1'b1;
              box_size_d = 64'd0;
            end else if (box_size_d < 64'(HDR_LEN_SMALL)) begin
              halt_d = STOP_BELOW;
            end
          end else if (hc_inc == HDR_LEN_LARGE && large_cur) begin
            if (box_size_d < 64'(HDR_LEN_LARGE)) begin
              halt_d = STOP_BELOW;
            end
          end
          hlen_new = large_d ? HDR_LEN_LARGE : HDR_LEN_SMALL;
          hdr_done = (hc_inc == hlen_new) && (halt_d == STOP_NONE);
          if (hdr_done) begin
            box_end_d = start_cur + box_size_d[POS_BITS-1:0];
            fit_d     = box_size_d <= (POS_MASK - 64'(start_cur));
            complete  = (box_size_d == 64'(hlen_new));
          end
        end else begin
          complete = fit_q && (pos_inc == box_end_q);
        end
        if (complete) begin
          if (mdat_d) begin
            commit_d = pos_inc;
          end
          hdr_cnt_d = '0;
        end
        byte_pos_d = pos_inc;
      end
    end

    if (halt_d != STOP_NONE) begin
      reason = halt_d;
    end else begin
      reason = (hdr_cnt_d == '0) ? STOP_NONE : STOP_PARTIAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= '0;
      box_start_q <= '0;
      hdr_cnt_q   <= '0;
      box_size_q  <= '0;
      large_q     <= 1'b0;
      mdat_q      <= 1'b0;
      commit_q    <= '0;
      halt_q      <= STOP_NONE;
      box_end_q   <= '0;
      fit_q       <= 1'b0;
    end else if (emit) begin
      // buffer finished: start afresh
      byte_pos_q  <= '0;
      box_start_q <= '0;
      hdr_cnt_q   <= '0;
      box_size_q  <= '0;
      large_q     <= 1'b0;
      mdat_q      <= 1'b0;
      commit_q    <= '0;
      halt_q      <= STOP_NONE;
      box_end_q   <= '0;
      fit_q       <= 1'b0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      box_start_q <= box_start_d;
      hdr_cnt_q   <= hdr_cnt_d;
      box_size_q  <= box_size_d;
      large_q     <= large_d;
      mdat_q      <= mdat_d;
      commit_q    <= commit_d;
      halt_q      <= halt_d;
      box_end_q   <= box_end_d;
      fit_q       <= fit_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {6'd0, reason, PREFIX_BITS'(64'(commit_d))};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(emit))
    else $error("result appeared without a last byte");

  a_hdr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q <= HDR_LEN_LARGE)
    else $error("header count out of range");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (byte_pos_q == '0 && halt_q == STOP_NONE && commit_q == '0))
    else $error("state not cleared after last byte");

  a_halt_freezes_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halt_q != STOP_NONE && !emit) |=> $stable(byte_pos_q))
    else $error("position moved after stop");

  a_commit_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_q <= byte_pos_q)
    else $error("committed end beyond position");

endmodule

@@ bench/bfps_checker.sv @@
`timescale 1ns / 1ps

// Watches both stream channels, walks the boxes of every accepted byte and
// compares each result beat against the oldest predicted verdict.
module bfps_checker
  import bfps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,
  input  logic                     s_axis_tlast,
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  localparam logic [31:0] FOURCC_MDAT = 32'h6D64_6174;

  typedef struct packed {
    logic [31:0] prefix_len;
    stop_e       reason;
  } buf_verdict_t;

  buf_verdict_t verdicts_due[$];

  // walker state
  logic [63:0]             pos;
  logic [63:0]             box_start;
  logic [63:0]             box_size;
  logic [63:0]             mdat_end;
  logic [HDR_CNT_BITS-1:0] hdr_cnt;
  logic                    large_hdr;
  logic                    is_mdat;
  stop_e                   halt;

  task automatic clear_walk();
    pos       = '0;
    box_start = '0;
    box_size  = '0;
    mdat_end  = '0;
    hdr_cnt   = '0;
    large_hdr = 1'b0;
    is_mdat   = 1'b0;
    halt      = STOP_NONE;
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic is_last);
    logic [HDR_CNT_BITS-1:0] hdr_len;
    logic [1:0]              tag_idx;
    buf_verdict_t            v;
    if (halt == STOP_NONE) begin
      if (pos >= POS_MASK) begin
        halt = STOP_PARTIAL;
      end else begin
        hdr_len = large_hdr ? HDR_LEN_LARGE : HDR_LEN_SMALL;
        if (hdr_cnt == '0) begin
          box_start = pos;
          box_size  = '0;
          large_hdr = 1'b0;
          is_mdat   = 1'b0;
          hdr_len   = HDR_LEN_SMALL;
        end
        if (hdr_cnt < hdr_len) begin
          if (hdr_cnt < HDR_TYPE_OFS || hdr_cnt >= HDR_LEN_SMALL) begin
            box_size = {box_size[55:0], b};
          end else begin
            tag_idx = 2'(hdr_cnt - HDR_TYPE_OFS);
            if (hdr_cnt == HDR_TYPE_OFS) is_mdat = 1'b1;
            if (b != FOURCC_MDAT[8*(3-tag_idx) +: 8]) is_mdat = 1'b0;
          end
          hdr_cnt = hdr_cnt + HDR_CNT_BITS'(1);
          if (hdr_cnt == HDR_LEN_SMALL && !large_hdr) begin
            if (box_size == 64'd0) begin
              halt = STOP_ZERO;
            end else if (box_size == 64'd1) begin
              large_hdr = 1'b1;
              box_size  = '0;
            end else if (box_size < 64'(HDR_LEN_SMALL)) begin
              halt = STOP_BELOW;
            end
          end else if (hdr_cnt == HDR_LEN_LARGE && large_hdr) begin
            if (box_size < 64'(HDR_LEN_LARGE)) halt = STOP_BELOW;
          end
        end
        pos = pos + 64'd1;
        hdr_len = large_hdr ? HDR_LEN_LARGE : HDR_LEN_SMALL;
        // box closes only if its end fits below the position ceiling
        if (halt == STOP_NONE && hdr_cnt == hdr_len &&
            box_size <= POS_MASK - box_start && pos - box_start == box_size) begin
          if (is_mdat) mdat_end = pos;
          hdr_cnt = '0;
        end
      end
    end
    if (is_last) begin
      v.prefix_len = mdat_end[31:0];
      if (halt != STOP_NONE) v.reason = halt;
      else v.reason = (hdr_cnt == '0) ? STOP_NONE : STOP_PARTIAL;
      verdicts_due.push_back(v);
      clear_walk();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    buf_verdict_t want;
    if (!rst_ni) begin
      clear_walk();
      verdicts_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) walk_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          $error("result beat with nothing expected: prefix_length %0d, stop_reason %0d",
                 m_axis_tdata[31:0], m_axis_tdata[33:32]);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = verdicts_due.pop_front();
          if (m_axis_tdata[31:0] !== want.prefix_len ||
              m_axis_tdata[33:32] !== want.reason) begin
            if (m_axis_tdata[31:0] !== want.prefix_len)
              $error("prefix_length: expected %0d, got %0d",
                     want.prefix_len, m_axis_tdata[31:0]);
            if (m_axis_tdata[33:32] !== want.reason)
              $error("stop_reason: expected %0d, got %0d",
                     want.reason, m_axis_tdata[33:32]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= verdicts_due.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the box walker. Each buffer is built as a byte
// list (boxes, then one of several endings) and streamed with tlast on its
// final beat. Three idle phases, a long receiver hold-off, and two pauses
// until all results are back.
module tb;
  import bfps_pkg::*;

  localparam int unsigned BYTES_PER_PHASE = 500;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned CYCLE_LIMIT     = 400_000;

  localparam logic [31:0] FOURCC_MDAT = 32'h6D64_6174;  // "mdat"
  localparam logic [31:0] FOURCC_MOOF = 32'h6D6F_6F66;  // "moof"

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata;   // [7:0] data_byte
  logic                     s_axis_tlast;   // last_byte
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;   // [31:0] prefix_length, [33:32] stop_reason

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  // idle odds in percent per cycle, changed per phase
  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  bit          sink_hold    = 1'b0;

  int unsigned phase_bytes;
  logic [7:0]  frame_q[$];

  always #5 clk_i = ~clk_i;

  bmff_fragment_prefix_scanner dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bfps_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random backpressure, or a long hold-off when requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        sink_hold = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  // Entered and left on a falling edge; waits out the handshake.
  task automatic push_beat(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      push_beat(frame_q[i], i == frame_q.size() - 1);
      phase_bytes++;
    end
    frame_q.delete();
  endtask

  // big-endian append
  task automatic put_be(input logic [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) frame_q.push_back(v[8*i +: 8]);
  endtask

  task automatic put_noise(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  function automatic logic [31:0] pick_fourcc();
    logic [31:0] f;
    case ($urandom_range(4))
      0, 1:    f = FOURCC_MDAT;
      2:       f = FOURCC_MOOF;
      3:       f = FOURCC_MDAT ^ (32'd1 << $urandom_range(31));  // near miss
      default: f = $urandom;
    endcase
    return f;
  endfunction

  // Complete box with a payload; large form uses size 1 plus a 64-bit size.
  task automatic add_box(input logic [31:0] fourcc, input int payload, input bit use_large);
    if (use_large) begin
      put_be(64'd1, 4);
      put_be(fourcc, 4);
      put_be(64'(HDR_LEN_LARGE) + 64'(payload), 8);
    end else begin
      put_be(64'(HDR_LEN_SMALL) + 64'(payload), 4);
      put_be(fourcc, 4);
    end
    put_noise(payload);
  endtask

  // Mostly well-formed boxes, then an ending that lands on one stop reason.
  task automatic build_frame();
    int unsigned cut;
    repeat ($urandom_range(3)) add_box(pick_fourcc(), $urandom_range(24), $urandom_range(3) == 0);
    case ($urandom_range(11))
      0, 1, 2: ;  // clean end on a box boundary
      3, 4: begin  // box cut short, inside header or payload
        add_box(pick_fourcc(), $urandom_range(24), $urandom_range(2) == 0);
        cut = $urandom_range(1, 20);
        repeat (cut) if (frame_q.size() > 0) void'(frame_q.pop_back());
      end
      5: begin  // zero size, then ignored bytes
        put_be(64'd0, 4);
        put_be(pick_fourcc(), 4);
        put_noise($urandom_range(6));
      end
      6: begin  // short size below header
        put_be(64'($urandom_range(2, 7)), 4);
        put_be(pick_fourcc(), 4);
        put_noise($urandom_range(6));
      end
      7: begin  // large size below header, zero included
        put_be(64'd1, 4);
        put_be(pick_fourcc(), 4);
        put_be(64'($urandom_range(15)), 8);
        put_noise($urandom_range(4));
      end
      8: begin  // size far beyond the buffer
        if ($urandom_range(1)) begin
          put_be(64'($urandom_range(32'hFFFF_FFFF, 32'h100)), 4);
          put_be(pick_fourcc(), 4);
        end else begin
          put_be(64'd1, 4);
          put_be(pick_fourcc(), 4);
          put_be({$urandom, $urandom} | 64'h100, 8);
        end
        put_noise($urandom_range(8));
      end
      9: begin  // large header cut short
        put_be(64'd1, 4);
        put_be(pick_fourcc(), 4);
        put_noise($urandom_range(7));
      end
      default: put_noise($urandom_range(1, 20));
    endcase
    if (frame_q.size() == 0) put_noise(1);
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned dst_pct);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    phase_bytes  = 0;
    while (phase_bytes < BYTES_PER_PHASE) begin
      build_frame();
      send_frame();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: lone 0xFF byte (partial), minimal mdat box,
    // zero size with a trailing ignored byte, large size below header.
    put_be(64'hFF, 1);
    send_frame();
    add_box(FOURCC_MDAT, 0, 1'b0);
    send_frame();
    put_be(64'd0, 4);
    put_be(FOURCC_MDAT, 4);
    put_be(64'd0, 1);
    send_frame();
    put_be(64'd1, 4);
    put_be(FOURCC_MDAT, 4);
    put_be(64'(HDR_LEN_LARGE) - 64'd1, 8);
    send_frame();

    run_phase(33, 61);
    run_phase(61, 33);

    // sender pauses until every result is back
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);

    // Receiver holds off while short buffers keep coming: only the last
    // beat of each buffer waits on m_axis, so the input side fills and stalls.
    sink_hold = 1'b1;
    src_idle_pct = 0;
    repeat (6) begin
      add_box(FOURCC_MDAT, $urandom_range(4), 1'b0);
      send_frame();
    end

    run_phase(0, 0);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
